// ----- design/ncs_pkg.sv -----
package ncs_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int SHIFT_IN = 25 - SAMPLE_WIDTH;
  localparam int FRAC = 24;
  localparam int WQ_W = SAMPLE_WIDTH + SHIFT_IN;
  localparam int ST_W = 32;
  localparam int ACC_W = 36;
  localparam int OP_W = 36;
  localparam int C_W = 27;
  localparam int P_W = OP_W + C_W;
  localparam int R_W = P_W - FRAC;
  localparam int NUM_SEC = 6;
  localparam int PC_W = 5;

  typedef logic signed [ST_W-1:0] state_word_t;
  typedef logic signed [C_W-1:0] coef_word_t;
  typedef logic signed [R_W-1:0] rnd_word_t;

  typedef enum logic [1:0] {
    COLOR_WHITE = 2'd0,
    COLOR_PINK  = 2'd1,
    COLOR_BROWN = 2'd2,
    COLOR_SPARE = 2'd3
  } color_t;

  typedef enum logic [2:0] {
    A_SEC   = 3'd0,
    A_W     = 3'd1,
    A_ACC   = 3'd2,
    A_BROWN = 3'd3,
    A_TMP   = 3'd4
  } a_sel_t;

  typedef enum logic [4:0] {
    C_POLE0, C_POLE1, C_POLE2, C_POLE3, C_POLE4, C_POLE5,
    C_GAIN0, C_GAIN1, C_GAIN2, C_GAIN3, C_GAIN4, C_GAIN5,
    C_DIRECT, C_OUTGAIN, C_TAP, C_BROWN_IN, C_BROWN_LEAK, C_BROWN_GAIN
  } coef_t;

  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_LOAD_TMP = 3'd1,
    ACT_SEC_WR   = 3'd2,
    ACT_ACC_ADD  = 3'd3,
    ACT_TAP_WR   = 3'd4,
    ACT_BROWN_T  = 3'd5,
    ACT_BROWN_WR = 3'd6,
    ACT_OUT      = 3'd7
  } act_t;

  typedef enum logic [1:0] {
    SEQ_WAIT = 2'd0,
    SEQ_NEXT = 2'd1,
    SEQ_DONE = 2'd2,
    SEQ_RAW  = 2'd3
  } seq_t;

  typedef struct packed {
    a_sel_t     a_sel;
    logic       mul_en;
    coef_t      coef;
    logic [2:0] rd_sec;
    logic [2:0] wr_sec;
    act_t       act;
    seq_t       seq;
  } uword_t;

  typedef struct packed {
    uword_t uw;
    logic   start;
    logic   advance;
  } ctl_t;

  localparam logic [PC_W-1:0] PC_WAIT = PC_W'(0);
  localparam logic [PC_W-1:0] PC_PINK = PC_W'(1);
  localparam logic [PC_W-1:0] PC_BROWN = PC_W'(17);
  localparam logic [PC_W-1:0] PC_WHITE = PC_W'(23);

  function automatic coef_word_t coef_value(input coef_t c);
    coef_word_t v;
    unique case (c)
      C_POLE0:      v = 27'sd16758090;
      C_POLE1:      v = 27'sd16665144;
      C_POLE2:      v = 27'sd16257122;
      C_POLE3:      v = 27'sd14537458;
      C_POLE4:      v = 27'sd9227469;
      C_POLE5:      v = -27'sd12777528;
      C_GAIN0:      v = 27'sd931436;
      C_GAIN1:      v = 27'sd1259565;
      C_GAIN2:      v = 27'sd2581208;
      C_GAIN3:      v = 27'sd5209084;
      C_GAIN4:      v = 27'sd8941454;
      C_GAIN5:      v = -27'sd283501;
      C_DIRECT:     v = 27'sd8995943;
      C_OUTGAIN:    v = 27'sd1845494;
      C_TAP:        v = 27'sd1944918;
      C_BROWN_IN:   v = 27'sd335544;
      C_BROWN_LEAK: v = 27'sd16448251;
      C_BROWN_GAIN: v = 27'sd58720256;
      default:      v = '0;
    endcase
    return v;
  endfunction

  function automatic uword_t mk_uw(input a_sel_t a, input logic m, input coef_t c,
                                   input int rd, input int wr, input act_t act,
                                   input seq_t sq);
    uword_t u;
    u.a_sel = a;
    u.mul_en = m;
    u.coef = c;
    u.rd_sec = 3'(rd);
    u.wr_sec = 3'(wr);
    u.act = act;
    u.seq = sq;
    return u;
  endfunction

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t u;
    unique case (pc)
      5'd0:  u = mk_uw(A_W, 1'b0, C_TAP, 0, 0, ACT_NONE, SEQ_WAIT);
      5'd1:  u = mk_uw(A_SEC, 1'b1, C_POLE0, 0, 0, ACT_NONE, SEQ_NEXT);
      5'd2:  u = mk_uw(A_W, 1'b1, C_GAIN0, 0, 0, ACT_LOAD_TMP, SEQ_NEXT);
      5'd3:  u = mk_uw(A_SEC, 1'b1, C_POLE1, 1, 0, ACT_SEC_WR, SEQ_NEXT);
      5'd4:  u = mk_uw(A_W, 1'b1, C_GAIN1, 0, 0, ACT_LOAD_TMP, SEQ_NEXT);
      5'd5:  u = mk_uw(A_SEC, 1'b1, C_POLE2, 2, 1, ACT_SEC_WR, SEQ_NEXT);
      5'd6:  u = mk_uw(A_W, 1'b1, C_GAIN2, 0, 0, ACT_LOAD_TMP, SEQ_NEXT);
      5'd7:  u = mk_uw(A_SEC, 1'b1, C_POLE3, 3, 2, ACT_SEC_WR, SEQ_NEXT);
      5'd8:  u = mk_uw(A_W, 1'b1, C_GAIN3, 0, 0, ACT_LOAD_TMP, SEQ_NEXT);
      5'd9:  u = mk_uw(A_SEC, 1'b1, C_POLE4, 4, 3, ACT_SEC_WR, SEQ_NEXT);
      5'd10: u = mk_uw(A_W, 1'b1, C_GAIN4, 0, 0, ACT_LOAD_TMP, SEQ_NEXT);
      5'd11: u = mk_uw(A_SEC, 1'b1, C_POLE5, 5, 4, ACT_SEC_WR, SEQ_NEXT);
      5'd12: u = mk_uw(A_W, 1'b1, C_GAIN5, 0, 0, ACT_LOAD_TMP, SEQ_NEXT);
      5'd13: u = mk_uw(A_W, 1'b1, C_DIRECT, 0, 5, ACT_SEC_WR, SEQ_NEXT);
      5'd14: u = mk_uw(A_W, 1'b1, C_TAP, 0, 0, ACT_ACC_ADD, SEQ_NEXT);
      5'd15: u = mk_uw(A_ACC, 1'b1, C_OUTGAIN, 0, 0, ACT_TAP_WR, SEQ_NEXT);
      5'd16: u = mk_uw(A_W, 1'b0, C_OUTGAIN, 0, 0, ACT_OUT, SEQ_DONE);
      5'd17: u = mk_uw(A_W, 1'b1, C_BROWN_IN, 0, 0, ACT_NONE, SEQ_NEXT);
      5'd18: u = mk_uw(A_W, 1'b0, C_BROWN_IN, 0, 0, ACT_BROWN_T, SEQ_NEXT);
      5'd19: u = mk_uw(A_TMP, 1'b1, C_BROWN_LEAK, 0, 0, ACT_NONE, SEQ_NEXT);
      5'd20: u = mk_uw(A_W, 1'b0, C_BROWN_LEAK, 0, 0, ACT_BROWN_WR, SEQ_NEXT);
      5'd21: u = mk_uw(A_BROWN, 1'b1, C_BROWN_GAIN, 0, 0, ACT_NONE, SEQ_NEXT);
      5'd22: u = mk_uw(A_W, 1'b0, C_BROWN_GAIN, 0, 0, ACT_OUT, SEQ_DONE);
      5'd23: u = mk_uw(A_W, 1'b0, C_TAP, 0, 0, ACT_OUT, SEQ_RAW);
      default: u = mk_uw(A_W, 1'b0, C_TAP, 0, 0, ACT_NONE, SEQ_DONE);
    endcase
    return u;
  endfunction

  function automatic rnd_word_t round_prod(input logic signed [P_W-1:0] p);
    logic signed [P_W-1:0] t;
    t = p + (P_W'(1) <<< (FRAC - 1));
    return t[P_W-1:FRAC];
  endfunction

  function automatic state_word_t sat32(input logic signed [R_W:0] x);
    logic signed [R_W:0] hi;
    logic signed [R_W:0] lo;
    state_word_t v;
    hi = (R_W+1)'(32'h7fff_ffff);
    lo = -hi - (R_W+1)'(1);
    if (x > hi) begin
      v = hi[ST_W-1:0];
    end else if (x < lo) begin
      v = lo[ST_W-1:0];
    end else begin
      v = x[ST_W-1:0];
    end
    return v;
  endfunction

  function automatic logic [SAMPLE_WIDTH-1:0] to_sample(input rnd_word_t y);
    logic signed [R_W:0] t;
    logic signed [R_W:0] v;
    logic signed [R_W:0] hi;
    logic signed [R_W:0] lo;
    logic [SAMPLE_WIDTH-1:0] s;
    hi = (R_W+1)'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);
    lo = -hi - (R_W+1)'(1);
    t = {y[R_W-1], y} + ((R_W+1)'(1) <<< (SHIFT_IN - 1));
    v = t >>> SHIFT_IN;
    if (v > hi) begin
      s = hi[SAMPLE_WIDTH-1:0];
    end else if (v < lo) begin
      s = lo[SAMPLE_WIDTH-1:0];
    end else begin
      s = v[SAMPLE_WIDTH-1:0];
    end
    return s;
  endfunction

endpackage

// ----- design/ncs_useq.sv -----
module ncs_useq (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wen,
  input  logic [1:0]    cfg_wdata,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          out_free,
  output ncs_pkg::ctl_t ctl
);
  import ncs_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  color_t          color;
  uword_t          uw;
  logic            start;
  logic            advance;
  logic [PC_W-1:0] entry;

  assign uw = ucode(pc);
  assign in_ready = (uw.seq == SEQ_WAIT);
  assign start = in_valid && in_ready;
  assign advance = !((uw.act == ACT_OUT) && !out_free);

  always_comb begin
    unique case (color)
      COLOR_PINK:  entry = PC_PINK;
      COLOR_BROWN: entry = PC_BROWN;
      default:     entry = PC_WHITE;
    endcase
  end

  always_comb begin
    pc_next = pc;
    unique case (uw.seq)
      SEQ_WAIT: begin
        if (start) begin
          pc_next = entry;
        end
      end
      SEQ_NEXT: begin
        if (advance) begin
          pc_next = pc + PC_W'(1);
        end
      end
      SEQ_DONE, SEQ_RAW: begin
        if (advance) begin
          pc_next = PC_WAIT;
        end
      end
      default: pc_next = PC_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_WAIT;
      color <= COLOR_PINK;
    end else begin
      pc <= pc_next;
      if (cfg_wen) begin
        color <= color_t'(cfg_wdata);
      end
    end
  end

  assign ctl.uw = uw;
  assign ctl.start = start;
  assign ctl.advance = advance;

endmodule

// ----- design/ncs_datapath.sv -----
module ncs_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  ncs_pkg::ctl_t                     ctl,
  input  logic [ncs_pkg::SAMPLE_WIDTH-1:0]  in_sample,
  input  logic                              in_last,
  output logic                              out_free,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ncs_pkg::SAMPLE_WIDTH-1:0]  out_sample,
  output logic                              out_last
);
  import ncs_pkg::*;

  state_word_t                 sections [NUM_SEC];
  state_word_t                 tap;
  state_word_t                 brown;
  logic signed [ACC_W-1:0]     acc;
  rnd_word_t                   tmp;
  logic signed [P_W-1:0]       prod;
  logic [SAMPLE_WIDTH-1:0]     sample;
  logic                        last;
  logic signed [WQ_W-1:0]      w;
  logic signed [OP_W-1:0]      a_op;
  state_word_t                 sec_rd;
  rnd_word_t                   r;
  state_word_t                 sec_new;
  logic                        step;
  logic                        fire_out;

  assign w = {sample, {SHIFT_IN{1'b0}}};
  assign sec_rd = sections[ctl.uw.rd_sec];
  assign r = round_prod(prod);
  assign sec_new = sat32({tmp[R_W-1], tmp} + {r[R_W-1], r});
  assign step = ctl.advance && !ctl.start;
  assign out_free = !out_valid || out_ready;
  assign fire_out = step && (ctl.uw.act == ACT_OUT);

  always_comb begin
    unique case (ctl.uw.a_sel)
      A_SEC:   a_op = OP_W'(sec_rd);
      A_W:     a_op = OP_W'(w);
      A_ACC:   a_op = acc;
      A_BROWN: a_op = OP_W'(brown);
      A_TMP:   a_op = tmp[OP_W-1:0];
      default: a_op = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      sample <= in_sample;
      last <= in_last;
      acc <= ACC_W'(tap);
    end
    if (step && ctl.uw.mul_en) begin
      prod <= a_op * coef_value(ctl.uw.coef);
    end
    if (step) begin
      unique case (ctl.uw.act)
        ACT_LOAD_TMP: tmp <= r;
        ACT_SEC_WR: acc <= acc + ACC_W'(sec_new);
        ACT_ACC_ADD: acc <= acc + ACC_W'(r);
        ACT_BROWN_T: tmp <= R_W'(brown) + r;
        default: ;
      endcase
    end
    if (fire_out) begin
      out_sample <= (ctl.uw.seq == SEQ_RAW) ? sample : to_sample(r);
      out_last <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_SEC; k++) begin
        sections[k] <= '0;
      end
      tap <= '0;
      brown <= '0;
      out_valid <= 1'b0;
    end else begin
      if (step && (ctl.uw.act == ACT_SEC_WR)) begin
        sections[ctl.uw.wr_sec] <= sec_new;
      end
      if (step && (ctl.uw.act == ACT_TAP_WR)) begin
        tap <= sat32({r[R_W-1], r});
      end
      if (step && (ctl.uw.act == ACT_BROWN_WR)) begin
        brown <= sat32({r[R_W-1], r});
      end
      if (fire_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- design/noise_color_shaper.sv -----
// Colors a stream of white-noise samples, one channel, signed Q1.15 in and out.
// The slave stream carries one white sample per item in tdata and a buffer-end
// flag in tlast; the master stream returns one colored sample per item with the
// same tlast. The color is set through cfg_wen and cfg_wdata: 0 white, 1 pink,
// 2 brown, 3 acts as white. Write it only while no item is in flight.
// A small microcode program drives one shared 36 x 27 bit multiplier; each step
// issues at most one product, which is registered before it is used.
// Pink takes 16 steps plus one idle step, brown 6 steps and white 1, each also
// plus the idle step; the result is registered at the program's output step.
// The next item is taken once the program returns to its wait step; only one
// item is in work at a time, and the program's step count sets the rate unless
// the program holds at its output step.
// The result waits in an output register, and a new item can be accepted while
// it does. If the receiver stalls long enough that the next result is ready
// before the old one is taken, the program holds at its output step.
// Reset selects pink and clears all filter and integrator state.
module noise_color_shaper (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wen,
  input  logic [1:0]                   cfg_wdata,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [ncs_pkg::TDATA_W-1:0]  s_axis_tdata,   // white_sample
  input  logic                         s_axis_tlast,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [ncs_pkg::TDATA_W-1:0]  m_axis_tdata,   // noise_out
  output logic                         m_axis_tlast
);
  import ncs_pkg::*;

  ctl_t                    ctl;
  logic                    out_free;
  logic [SAMPLE_WIDTH-1:0] out_sample;

  ncs_useq u_useq (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_free  (out_free),
    .ctl       (ctl)
  );

  ncs_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .in_sample  (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .in_last    (s_axis_tlast),
    .out_free   (out_free),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_sample (out_sample),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = TDATA_W'(out_sample);

endmodule

// ----- design/ncs_checker.sv -----
module ncs_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [ncs_pkg::TDATA_W-1:0]  m_axis_tdata,
  input logic                         m_axis_tlast
);

  // A result that is not taken holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // Only one item is in work, so the input is closed in the cycle after acceptance.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is in work");

  // A new result only appears at the end of the program, never while waiting.
  a_rise_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared while the sequencer was idle");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind noise_color_shaper ncs_checker u_ncs_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
